### design/sfbm_pkg.sv
// shared types and constants for the surface format best match select unit
package sfbm_pkg;

  localparam int unsigned ScoreW    = 33;
  localparam int unsigned PaddrW    = 5;
  localparam int unsigned PdataW    = 32;

  localparam int unsigned SbufShift = 29;
  localparam int unsigned SampShift = 24;
  localparam int unsigned ColShift  = 17;
  localparam int unsigned DepShift  = 11;
  localparam int unsigned LinShift  = 10;
  localparam int unsigned StnShift  = 6;

  typedef enum logic [2:0] {
    REG_COLOR   = 3'd0,
    REG_ALPHA   = 3'd1,
    REG_DEPTH   = 3'd2,
    REG_STENCIL = 3'd3,
    REG_QUALITY = 3'd4,
    REG_MSAA    = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [5:0] target_color_bits;
    logic [5:0] target_alpha_bits;
    logic [5:0] target_depth_bits;
    logic [5:0] target_stencil_bits;
    logic       prefer_quality;
    logic       multisample_wanted;
  } cfg_t;

  typedef struct packed {
    logic [15:0] candidate_id;
    logic [5:0]  red_bits;
    logic [5:0]  green_bits;
    logic [5:0]  blue_bits;
    logic [5:0]  alpha_bits;
    logic [5:0]  depth_bits;
    logic [5:0]  stencil_bits;
    logic [4:0]  sample_buffer_count;
    logic [5:0]  sample_count;
    logic        nonlinear_depth;
    logic        last_candidate;
  } cand_t;

  typedef struct packed {
    logic [ScoreW-1:0] score;
    logic              ms_ok;
  } score_t;

  typedef struct packed {
    logic [15:0]       chosen_id;
    logic [5:0]        chosen_depth;
    logic [5:0]        chosen_stencil;
    logic [4:0]        chosen_sample_buffers;
    logic [5:0]        chosen_samples;
    logic [ScoreW-1:0] chosen_score;
    logic              taken_as_fallback;
  } res_t;

endpackage

### design/sfbm_if.sv
// request channel interfaces for candidates and results
interface sfbm_cand_if;
  logic        valid;
  logic        ready;
  logic [15:0] candidate_id;
  logic [5:0]  red_bits;
  logic [5:0]  green_bits;
  logic [5:0]  blue_bits;
  logic [5:0]  alpha_bits;
  logic [5:0]  depth_bits;
  logic [5:0]  stencil_bits;
  logic [4:0]  sample_buffer_count;
  logic [5:0]  sample_count;
  logic        nonlinear_depth;
  logic        last_candidate;

  modport source (
    output valid, candidate_id, red_bits, green_bits, blue_bits, alpha_bits,
           depth_bits, stencil_bits, sample_buffer_count, sample_count,
           nonlinear_depth, last_candidate,
    input  ready
  );
  modport sink (
    input  valid, candidate_id, red_bits, green_bits, blue_bits, alpha_bits,
           depth_bits, stencil_bits, sample_buffer_count, sample_count,
           nonlinear_depth, last_candidate,
    output ready
  );
endinterface

interface sfbm_res_if;
  logic        valid;
  logic        ready;
  logic [15:0] chosen_id;
  logic [5:0]  chosen_depth;
  logic [5:0]  chosen_stencil;
  logic [4:0]  chosen_sample_buffers;
  logic [5:0]  chosen_samples;
  logic [32:0] chosen_score;
  logic        taken_as_fallback;

  modport source (
    output valid, chosen_id, chosen_depth, chosen_stencil, chosen_sample_buffers,
           chosen_samples, chosen_score, taken_as_fallback,
    input  ready
  );
  modport sink (
    input  valid, chosen_id, chosen_depth, chosen_stencil, chosen_sample_buffers,
           chosen_samples, chosen_score, taken_as_fallback,
    output ready
  );
endinterface

### design/sfbm_cfg_regs.sv
// apb configuration registers
module sfbm_cfg_regs
  import sfbm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  output logic [PdataW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[PaddrW-1:2]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_COLOR:   cfg_d.target_color_bits   = pwdata[5:0];
        REG_ALPHA:   cfg_d.target_alpha_bits   = pwdata[5:0];
        REG_DEPTH:   cfg_d.target_depth_bits   = pwdata[5:0];
        REG_STENCIL: cfg_d.target_stencil_bits = pwdata[5:0];
        REG_QUALITY: cfg_d.prefer_quality      = pwdata[0];
        REG_MSAA:    cfg_d.multisample_wanted  = pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_COLOR:   prdata = PdataW'(cfg_q.target_color_bits);
      REG_ALPHA:   prdata = PdataW'(cfg_q.target_alpha_bits);
      REG_DEPTH:   prdata = PdataW'(cfg_q.target_depth_bits);
      REG_STENCIL: prdata = PdataW'(cfg_q.target_stencil_bits);
      REG_QUALITY: prdata = PdataW'(cfg_q.prefer_quality);
      REG_MSAA:    prdata = PdataW'(cfg_q.multisample_wanted);
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target_color_bits   <= 6'd8;
      cfg_q.target_alpha_bits   <= 6'd8;
      cfg_q.target_depth_bits   <= 6'd24;
      cfg_q.target_stencil_bits <= 6'd8;
      cfg_q.prefer_quality      <= 1'b0;
      cfg_q.multisample_wanted  <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### design/sfbm_score.sv
// packed priority score and multisample check for one candidate
module sfbm_score
  import sfbm_pkg::*;
(
  input  cand_t  cand_i,
  input  cfg_t   cfg_i,
  output score_t score_o
);

  function automatic logic [5:0] dist6(input logic [5:0] a, input logic [5:0] b);
    dist6 = (a >= b) ? (a - b) : (b - a);
  endfunction

  logic [5:0] d_r, d_g, d_b, d_a, d_d, d_s;
  logic [7:0] col_sum;
  logic [6:0] col_sat;
  logic [4:0] stn_sat, alp_sat, samp_sat;
  logic [3:0] sbuf_sat;

  always_comb begin
    d_r = dist6(cand_i.red_bits,     cfg_i.target_color_bits);
    d_g = dist6(cand_i.green_bits,   cfg_i.target_color_bits);
    d_b = dist6(cand_i.blue_bits,    cfg_i.target_color_bits);
    d_a = dist6(cand_i.alpha_bits,   cfg_i.target_alpha_bits);
    d_d = dist6(cand_i.depth_bits,   cfg_i.target_depth_bits);
    d_s = dist6(cand_i.stencil_bits, cfg_i.target_stencil_bits);

    col_sum  = {2'b00, d_r} + {2'b00, d_g} + {2'b00, d_b};
    col_sat  = col_sum[7] ? 7'd127 : col_sum[6:0];
    stn_sat  = d_s[5] ? 5'd31 : d_s[4:0];
    alp_sat  = d_a[5] ? 5'd31 : d_a[4:0];
    samp_sat = cand_i.sample_count[5] ? 5'd31 : cand_i.sample_count[4:0];
    sbuf_sat = cand_i.sample_buffer_count[4] ? 4'd15 : cand_i.sample_buffer_count[3:0];

    score_o.score = (ScoreW'(sbuf_sat) << SbufShift)
                  | (ScoreW'(samp_sat) << SampShift)
                  | (ScoreW'(col_sat)  << ColShift)
                  | (ScoreW'(d_d)      << DepShift)
                  | (ScoreW'(!cand_i.nonlinear_depth) << LinShift)
                  | (ScoreW'(stn_sat)  << StnShift)
                  | ScoreW'(alp_sat);

    if (cfg_i.multisample_wanted) begin
      score_o.ms_ok = (cand_i.sample_buffer_count != '0) && (cand_i.sample_count != '0);
    end else begin
      score_o.ms_ok = (cand_i.sample_buffer_count == '0) && (cand_i.sample_count == '0);
    end
  end

endmodule

### design/sfbm_select.sv
// running best candidate and result register
module sfbm_select
  import sfbm_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   item_valid_i,
  input  cand_t  item_i,
  input  score_t score_i,
  input  logic   prefer_quality_i,
  input  logic   res_ready_i,
  output logic   item_fire_o,
  output logic   res_valid_o,
  output res_t   res_o
);

  logic              have_q, have_d;
  logic [ScoreW-1:0] best_score_q, best_score_d;
  logic [15:0]       best_id_q, best_id_d;
  logic [5:0]        best_depth_q, best_depth_d;
  logic [5:0]        best_stencil_q, best_stencil_d;
  logic [4:0]        best_sbuf_q, best_sbuf_d;
  logic [5:0]        best_samp_q, best_samp_d;
  logic              res_valid_q, res_valid_d;
  res_t              res_q, res_d;

  logic better, normal, fallback, take, fire, last;

  assign last = item_i.last_candidate;
  assign fire = item_valid_i && (!last || !res_valid_q || res_ready_i);

  always_comb begin
    if (!have_q) begin
      better = 1'b1;
    end else if (prefer_quality_i) begin
      better = score_i.score >= best_score_q;
    end else begin
      better = score_i.score < best_score_q;
    end
    normal   = better && score_i.ms_ok;
    fallback = !normal && !have_q && last;
    take     = fire && (normal || fallback);
  end

  always_comb begin
    have_d         = have_q;
    best_score_d   = best_score_q;
    best_id_d      = best_id_q;
    best_depth_d   = best_depth_q;
    best_stencil_d = best_stencil_q;
    best_sbuf_d    = best_sbuf_q;
    best_samp_d    = best_samp_q;
    if (take) begin
      have_d         = 1'b1;
      best_score_d   = score_i.score;
      best_id_d      = item_i.candidate_id;
      best_depth_d   = item_i.depth_bits;
      best_stencil_d = item_i.stencil_bits;
      best_sbuf_d    = item_i.sample_buffer_count;
      best_samp_d    = item_i.sample_count;
    end
    if (fire && last) begin
      have_d = 1'b0;
    end
  end

  always_comb begin
    res_d       = res_q;
    res_valid_d = res_valid_q && !res_ready_i;
    if (fire && last) begin
      res_valid_d                 = 1'b1;
      res_d.chosen_id             = best_id_d;
      res_d.chosen_depth          = best_depth_d;
      res_d.chosen_stencil        = best_stencil_d;
      res_d.chosen_sample_buffers = best_sbuf_d;
      res_d.chosen_samples        = best_samp_d;
      res_d.chosen_score          = best_score_d;
      res_d.taken_as_fallback     = fallback;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      have_q      <= have_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_score_q   <= best_score_d;
    best_id_q      <= best_id_d;
    best_depth_q   <= best_depth_d;
    best_stencil_q <= best_stencil_d;
    best_sbuf_q    <= best_sbuf_d;
    best_samp_q    <= best_samp_d;
    res_q          <= res_d;
  end

  assign item_fire_o = fire;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

`ifndef SYNTH
  a_last_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && last |=> res_valid_q)
    else $error("last candidate did not produce a result");

  a_last_clears_choice: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && last |=> !have_q)
    else $error("running choice not cleared after last candidate");

  a_take_sets_choice: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && !last |=> have_q)
    else $error("taken candidate not recorded");

  a_full_blocks_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && !res_ready_i && item_valid_i && last |-> !fire)
    else $error("last candidate consumed while result register full");
`endif

endmodule

### design/surface_format_best_match_select_unit.sv
// top level of the surface format best match select unit
// the last candidate is held in the input register and, once it fires, the result is captured in the result register
// throughput: one candidate per cycle, set by the single score and compare stage, while no last candidate is held back
// a last candidate waits in the input register only while the result register is full and not being read
// reset: clears valid flags and the running choice, configuration returns to 8, 8, 24, 8, 0, 0
module surface_format_best_match_select_unit
  import sfbm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  output logic [PdataW-1:0] prdata,
  output logic              pready,
  sfbm_cand_if.sink         cand_i,
  sfbm_res_if.source        result_o
);

  cfg_t   cfg;
  cand_t  in_item;
  cand_t  item_q;
  logic   item_valid_q, item_valid_d;
  logic   item_fire, in_accept;
  score_t score;
  res_t   res;
  logic   res_valid;

  sfbm_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  always_comb begin
    in_item.candidate_id        = cand_i.candidate_id;
    in_item.red_bits            = cand_i.red_bits;
    in_item.green_bits          = cand_i.green_bits;
    in_item.blue_bits           = cand_i.blue_bits;
    in_item.alpha_bits          = cand_i.alpha_bits;
    in_item.depth_bits          = cand_i.depth_bits;
    in_item.stencil_bits        = cand_i.stencil_bits;
    in_item.sample_buffer_count = cand_i.sample_buffer_count;
    in_item.sample_count        = cand_i.sample_count;
    in_item.nonlinear_depth     = cand_i.nonlinear_depth;
    in_item.last_candidate      = cand_i.last_candidate;
  end

  assign cand_i.ready = !item_valid_q || item_fire;
  assign in_accept    = cand_i.valid && cand_i.ready;

  always_comb begin
    item_valid_d = item_valid_q;
    if (in_accept) begin
      item_valid_d = 1'b1;
    end else if (item_fire) begin
      item_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else begin
      item_valid_q <= item_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q <= in_item;
    end
  end

  sfbm_score u_score (
    .cand_i  (item_q),
    .cfg_i   (cfg),
    .score_o (score)
  );

  sfbm_select u_select (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .item_valid_i     (item_valid_q),
    .item_i           (item_q),
    .score_i          (score),
    .prefer_quality_i (cfg.prefer_quality),
    .res_ready_i      (result_o.ready),
    .item_fire_o      (item_fire),
    .res_valid_o      (res_valid),
    .res_o            (res)
  );

  assign result_o.valid                 = res_valid;
  assign result_o.chosen_id             = res.chosen_id;
  assign result_o.chosen_depth          = res.chosen_depth;
  assign result_o.chosen_stencil        = res.chosen_stencil;
  assign result_o.chosen_sample_buffers = res.chosen_sample_buffers;
  assign result_o.chosen_samples        = res.chosen_samples;
  assign result_o.chosen_score          = res.chosen_score;
  assign result_o.taken_as_fallback     = res.taken_as_fallback;

endmodule
